// ===== rtl/hkst_pkg.sv =====
package hkst_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 16;
    localparam int HELD_W   = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_MOVE  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    // held_count is reported as the low bits of the fill count
    function automatic logic [HELD_W-1:0] held_bits(input logic [CNT_W-1:0] c);
        logic [CNT_W+HELD_W-1:0] w;
        w = {{HELD_W{1'b0}}, c};
        return w[HELD_W-1:0];
    endfunction

endpackage

// ===== rtl/hkst_ram.sv =====
module hkst_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/held_key_set_tracker_top.sv =====
// channel   signals                                   handshake
// input     op, key_code, pressed                     start high while busy low
// result    accepted, out_key, key_valid,             strobe, one cycle per beat
//           held_count, last
//
// a key event does one key store read per cycle
// during the search, then one read and one write to move the last entry on a release.
// a flush does one stored key read per result beat.
// reset clears the fill count and the control state; the key store itself is never cleared.
// results cannot be stalled; busy stays high until the last beat is sent.
module held_key_set_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] key_code,
    input  logic        pressed,
    output logic        strobe,
    output logic        accepted,
    output logic [15:0] out_key,
    output logic        key_valid,
    output logic [4:0]  held_count,
    output logic        last
);

    hkst_pkg::state_t state_reg, state_next;

    logic [hkst_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [hkst_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [hkst_pkg::CNT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic                        pend_reg, pend_next;
    logic                        pend_last_reg, pend_last_next;
    logic [hkst_pkg::ADDR_W-1:0] slot_reg, slot_next;
    logic [hkst_pkg::KEY_W-1:0]  key_reg, key_next;
    logic                        press_reg, press_next;

    logic                        strobe_reg, strobe_next;
    logic                        accepted_reg, accepted_next;
    logic [hkst_pkg::KEY_W-1:0]  out_key_reg, out_key_next;
    logic                        key_valid_reg, key_valid_next;
    logic [hkst_pkg::HELD_W-1:0] held_reg, held_next;
    logic                        last_reg, last_next;

    logic                        ram_we;
    logic [hkst_pkg::ADDR_W-1:0] ram_waddr;
    logic [hkst_pkg::KEY_W-1:0]  ram_wdata;
    logic [hkst_pkg::ADDR_W-1:0] ram_raddr;
    logic [hkst_pkg::KEY_W-1:0]  ram_rdata;

    logic                        hit;
    logic [hkst_pkg::CNT_W-1:0]  count_dec;

    hkst_ram #(
        .WIDTH  (hkst_pkg::KEY_W),
        .DEPTH  (hkst_pkg::CAPACITY),
        .ADDR_W (hkst_pkg::ADDR_W)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit       = pend_reg && (ram_rdata == key_reg);
    assign count_dec = count_reg - hkst_pkg::CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_idx_next  = pend_idx_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        slot_next      = slot_reg;
        key_next       = key_reg;
        press_next     = press_reg;

        strobe_next    = 1'b0;
        accepted_next  = accepted_reg;
        out_key_next   = out_key_reg;
        key_valid_next = key_valid_reg;
        held_next      = held_reg;
        last_next      = last_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = key_reg;
        ram_raddr = idx_reg[hkst_pkg::ADDR_W-1:0];

        case (state_reg)
            hkst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key_code;
                    press_next = pressed;
                    idx_next   = '0;
                    if (op == hkst_pkg::OP_EVENT)
                    begin
                        state_next = hkst_pkg::ST_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        strobe_next    = 1'b1;
                        accepted_next  = 1'b1;
                        out_key_next   = '0;
                        key_valid_next = 1'b0;
                        held_next      = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = hkst_pkg::ST_FLUSH;
                    end
                end
            end

            hkst_pkg::ST_SCAN:
            begin
                strobe_next    = 1'b0;
                accepted_next  = 1'b1;
                out_key_next   = key_reg;
                key_valid_next = 1'b1;
                last_next      = 1'b1;
                held_next      = hkst_pkg::held_bits(count_reg);
                if (hit)
                begin
                    if (press_reg)
                    begin
                        // duplicate press
                        strobe_next   = 1'b1;
                        accepted_next = 1'b0;
                        state_next    = hkst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // fetch the last entry to fill the hole
                        ram_raddr  = count_dec[hkst_pkg::ADDR_W-1:0];
                        slot_next  = pend_idx_reg[hkst_pkg::ADDR_W-1:0];
                        state_next = hkst_pkg::ST_MOVE;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + hkst_pkg::CNT_W'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    state_next  = hkst_pkg::ST_IDLE;
                    if (press_reg)
                    begin
                        if (count_reg >= hkst_pkg::CNT_W'(hkst_pkg::CAPACITY))
                        begin
                            accepted_next = 1'b0;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[hkst_pkg::ADDR_W-1:0];
                            ram_wdata  = key_reg;
                            count_next = count_reg + hkst_pkg::CNT_W'(1);
                            held_next  = hkst_pkg::held_bits(count_next);
                        end
                    end
                end
            end

            hkst_pkg::ST_MOVE:
            begin
                ram_we         = 1'b1;
                ram_waddr      = slot_reg;
                ram_wdata      = ram_rdata;
                count_next     = count_dec;
                strobe_next    = 1'b1;
                accepted_next  = 1'b1;
                out_key_next   = key_reg;
                key_valid_next = 1'b1;
                held_next      = hkst_pkg::held_bits(count_dec);
                last_next      = 1'b1;
                state_next     = hkst_pkg::ST_IDLE;
            end

            hkst_pkg::ST_FLUSH:
            begin
                if (idx_reg < count_reg)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = (idx_reg == count_dec);
                    idx_next       = idx_reg + hkst_pkg::CNT_W'(1);
                end
                if (pend_reg)
                begin
                    strobe_next    = 1'b1;
                    accepted_next  = 1'b1;
                    out_key_next   = ram_rdata;
                    key_valid_next = 1'b1;
                    held_next      = '0;
                    last_next      = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        count_next = '0;
                        state_next = hkst_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = hkst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hkst_pkg::ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        slot_reg      <= slot_next;
        key_reg       <= key_next;
        press_reg     <= press_next;
        accepted_reg  <= accepted_next;
        out_key_reg   <= out_key_next;
        key_valid_reg <= key_valid_next;
        held_reg      <= held_next;
        last_reg      <= last_next;
    end

    assign busy       = (state_reg != hkst_pkg::ST_IDLE);
    assign strobe     = strobe_reg;
    assign accepted   = accepted_reg;
    assign out_key    = out_key_reg;
    assign key_valid  = key_valid_reg;
    assign held_count = held_reg;
    assign last       = last_reg;

    // flush beats leave back to back until the last one
    a_flush_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("flush beat stream broken");

    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !key_valid |-> held_count == '0 && last && accepted)
        else $error("empty flush beat malformed");

    a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("item finished without a last beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> count_reg <= hkst_pkg::CNT_W'(hkst_pkg::CAPACITY))
        else $error("held key count above capacity");

endmodule
